// File: src/isodte_pkg.sv
// isodte_pkg: shared widths, constants, control struct and the month table
// for the disc date to epoch seconds converter; no dependencies
`default_nettype none

package isodte_pkg;

    localparam int YearW = 14;
    localparam int DaysW = 24;
    localparam int SecsW = 39;
    localparam int UsecW = 20;
    localparam int HmsW  = 20;
    localparam int SmallW = 22;

    // floor(x / 100) == (x * Recip100) >> Recip100Shift for every x below 2**14
    localparam logic [12:0] Recip100      = 13'd5243;
    localparam int          Recip100Shift = 19;

    // days from 0000-12-31 to 1970-01-01
    localparam logic signed [DaysW:0] EpochDays = 25'sd719163;
    // days from 0000-12-31 back to the start of year zero, hence negative
    localparam logic signed [DaysW:0] YearZeroDays = -25'sd365;

    localparam logic signed [17:0] SecsPerDay  = 18'sd86400;
    localparam logic [9:0]         SecsPerStep = 10'd900;
    localparam logic [13:0]        UsecPerHund = 14'd10000;
    localparam logic [6:0]         HundMax     = 7'd99;

    localparam logic [7:0] MonthFirst = 8'd1;
    localparam logic [7:0] MonthLast  = 8'd12;
    localparam logic [7:0] DayFirst   = 8'd1;
    localparam logic [7:0] DayLast    = 8'd31;
    localparam logic [7:0] MonthMar   = 8'd3;

    typedef struct packed {
        logic valid;
        logic date_ok;
    } t_stage_ctl;

    // days before the first of a month, index is month - 1
    function automatic logic [8:0] days_before(input logic [3:0] m0);
        logic [8:0] d;
        case (m0)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// File: src/isodte_if.sv
// isodte_in_if / isodte_out_if: valid-ready channels carrying one date item
// and one epoch result item; no dependencies
`default_nettype none

interface isodte_in_if;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [13:0]       year;
    logic [7:0]        month;
    logic [7:0]        day;
    logic [7:0]        hour;
    logic [7:0]        minute;
    logic [7:0]        second;
    logic [6:0]        hundredths;
    logic signed [7:0] gmt_offset;

    modport source (
        output valid, req_type, year, month, day, hour, minute, second,
               hundredths, gmt_offset,
        input  ready
    );
    modport sink (
        input  valid, req_type, year, month, day, hour, minute, second,
               hundredths, gmt_offset,
        output ready
    );
endinterface

interface isodte_out_if;
    logic               valid;
    logic               ready;
    logic signed [38:0] epoch_seconds;
    logic [19:0]        microseconds;

    modport source (
        output valid, epoch_seconds, microseconds,
        input  ready
    );
    modport sink (
        input  valid, epoch_seconds, microseconds,
        output ready
    );
endinterface

`default_nettype wire

// File: src/isodte_day_count.sv
// isodte_day_count: two-stage pipeline turning year, month and day into a
// signed day count from 1970-01-01; uses isodte_pkg
`default_nettype none

module isodte_day_count
    import isodte_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire logic [YearW-1:0]        i_year,
    input  wire logic [7:0]              i_month,
    input  wire logic [7:0]              i_day,
    output      t_stage_ctl              o_ctl,
    output      logic signed [DaysW-1:0] o_days
);

    // stage 1: reciprocal products for the century and 400-year counts, month table, date check
    logic             r1_valid;
    logic             r1_ok;
    logic             r1_year0;
    logic [YearW-1:0] r1_y;
    logic [YearW-1:0] r1_year;
    logic [26:0]      r1_py100;
    logic [24:0]      r1_py400;
    logic [26:0]      r1_pyr100;
    logic [8:0]       r1_dbm;
    logic             r1_mar;
    logic [7:0]       r1_day;

    logic             n1_ok;
    logic [YearW-1:0] n1_y;

    always_comb begin
        n1_ok = (i_month inside {[MonthFirst:MonthLast]})
             && (i_day inside {[DayFirst:DayLast]});
        n1_y  = i_year - YearW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ok     <= n1_ok;
            r1_year0  <= (i_year == '0);
            r1_y      <= n1_y;
            r1_year   <= i_year;
            r1_py100  <= 27'(n1_y) * 27'(Recip100);
            r1_py400  <= 25'(n1_y[YearW-1:2]) * 25'(Recip100);
            r1_pyr100 <= 27'(i_year) * 27'(Recip100);
            r1_dbm    <= days_before(i_month[3:0] - 4'd1);
            r1_mar    <= (i_month >= MonthMar);
            r1_day    <= i_day;
        end
    end

    // stage 2: days through the previous year, month table, leap day
    logic [7:0]             q100;
    logic [5:0]             q400;
    logic [7:0]             qy100;
    logic                   leap;
    logic signed [DaysW:0]  dt;
    logic signed [DaysW:0]  n2_days;

    always_comb begin
        q100  = r1_py100[Recip100Shift +: 8];
        q400  = r1_py400[Recip100Shift +: 6];
        qy100 = r1_pyr100[Recip100Shift +: 8];
        leap  = (r1_year[1:0] == 2'b00)
             && ((r1_year != 14'(qy100) * 14'd100) || (qy100[1:0] == 2'b00));
        if (r1_year0) begin
            dt = YearZeroDays;
        end else begin
            dt = signed'(25'(r1_y) * 25'd365 + 25'(r1_y[YearW-1:2])
                 - 25'(q100) + 25'(q400) + 25'd1);
        end
        n2_days = dt - EpochDays + signed'(25'(r1_dbm))
                + signed'(25'(r1_mar && leap)) + signed'(25'(r1_day)) - 25'sd1;
    end

    logic                    r2_valid;
    logic                    r2_ok;
    logic signed [DaysW-1:0] r2_days;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ok   <= r1_ok;
            r2_days <= n2_days[DaysW-1:0];
        end
    end

    assign o_ctl.valid   = r2_valid;
    assign o_ctl.date_ok = r2_ok;
    assign o_days        = r2_days;

    // a checked date stays within the span of 14-bit years
    a_days_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_valid && r2_ok |-> (r2_days >= -24'sd719528) && (r2_days <= 24'sd5264830))
        else $error("day count out of range");

endmodule

`default_nettype wire

// File: src/iso9660_date_to_epoch.sv
// iso9660_date_to_epoch: top level, converts a disc date record into signed
// epoch seconds and microseconds; uses isodte_pkg, isodte_if, isodte_day_count
`default_nettype none

// usage
//   i_in is a valid-ready sink carrying one date item: format select, year,
//   month, day, hour, minute, second, hundredths and utc offset in quarter hours
//   o_out is a valid-ready source carrying one result item per date item:
//   signed seconds since 1970-01-01 utc and a microsecond part
//   a month outside 1..12 or a day outside 1..31 gives an all-zero result
//   pipeline: four register stages; the accepting edge loads stage 1, each
//   advance moves the item on, and o_out.valid rises once stage 4 holds it
//     stage 1  reciprocal products, month table, time of day, offset seconds
//     stage 2  day count, time of day minus offset
//     stage 3  day count times seconds per day (24 x 18 multiplier)
//     stage 4  final add into the output register
//   throughput: one item per cycle when not stalled, the pipeline has no loop
//   stall: the whole pipeline holds while the output register keeps an item
//   that o_out has not taken; i_in.ready is low only then, so nothing is lost
//   or repeated and empty stages do not stop new items
//   reset: synchronous active low, clears the valid bits of every stage

module iso9660_date_to_epoch
    import isodte_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    isodte_in_if.sink      i_in,
    isodte_out_if.source   o_out
);

    // pipeline advance: the output register is empty or being drained
    logic en;
    logic r4_valid;

    assign en         = !r4_valid || o_out.ready;
    assign i_in.ready = en;

    // day count lives in its own two stages
    t_stage_ctl              days_ctl;
    logic signed [DaysW-1:0] days;

    isodte_day_count u_day_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_year  (i_in.year),
        .i_month (i_in.month),
        .i_day   (i_in.day),
        .o_ctl   (days_ctl),
        .o_days  (days)
    );

    // stage 1: time of day in seconds, offset in seconds, microseconds
    logic [6:0]        hund_clamped;
    logic [HmsW-1:0]   n1_hms;
    logic [UsecW-1:0]  n1_usec;

    always_comb begin
        hund_clamped = (i_in.hundredths > HundMax) ? HundMax : i_in.hundredths;
        n1_hms  = HmsW'(i_in.hour) * HmsW'(12'd3600)
                + HmsW'(i_in.minute) * HmsW'(6'd60)
                + HmsW'(i_in.second);
        // short format never carries a sub-second part
        n1_usec = i_in.req_type ? UsecW'(hund_clamped) * UsecW'(UsecPerHund) : '0;
    end

    logic [HmsW-1:0]    r1_hms;
    logic signed [17:0] r1_off_secs;
    logic [UsecW-1:0]   r1_usec;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_hms      <= n1_hms;
            r1_off_secs <= 18'(i_in.gmt_offset) * signed'({8'd0, SecsPerStep});
            r1_usec     <= n1_usec;
        end
    end

    // stage 2: local time of day shifted to utc
    logic signed [SmallW-1:0] r2_small;
    logic [UsecW-1:0]         r2_usec;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_small <= signed'(SmallW'(r1_hms)) - SmallW'(r1_off_secs);
            r2_usec  <= r1_usec;
        end
    end

    // stage 3: whole days to seconds, kept modulo 2**39
    logic signed [DaysW+17:0] day_secs;
    logic                     r3_valid;
    logic                     r3_ok;
    logic signed [SecsW-1:0]  r3_day_secs;
    logic signed [SmallW-1:0] r3_small;
    logic [UsecW-1:0]         r3_usec;

    assign day_secs = days * SecsPerDay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= days_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ok       <= days_ctl.date_ok;
            r3_day_secs <= day_secs[SecsW-1:0];
            r3_small    <= r2_small;
            r3_usec     <= r2_usec;
        end
    end

    // stage 4: output register, invalid dates read as zero
    logic signed [SecsW-1:0] r4_secs;
    logic [UsecW-1:0]        r4_usec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_secs <= r3_ok ? r3_day_secs + SecsW'(r3_small) : '0;
            r4_usec <= r3_ok ? r3_usec : '0;
        end
    end

    assign o_out.valid         = r4_valid;
    assign o_out.epoch_seconds = r4_secs;
    assign o_out.microseconds  = r4_usec;

    // an item accepted into a pipeline that then advances through stages 2, 3 and 4 without a stall is out
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) ##1 en ##1 en ##1 en |=> o_out.valid)
        else $error("item did not reach the output after four advances");

    // the sub-second part never exceeds the clamped hundredths
    a_usec_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.microseconds <= 20'd990000)
        else $error("microseconds above clamp");

    // invalid date yields zero seconds and zero microseconds together
    a_zero_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r3_valid && !r3_ok |=> o_out.valid && (o_out.epoch_seconds == '0)
                                     && (o_out.microseconds == '0))
        else $error("invalid date not zeroed");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
